// File: rtl/ipw_pkg.sv
// ============================================================================
// ipw_pkg: shared types and constants for the indexed pixel 1bpp writer
// Widths, opcodes, register indexes, control/status structs and the
// palette threshold function.
// ============================================================================
package ipw_pkg;

    // Sizing
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 256;
    localparam int PALETTE_SIZE = 256;
    localparam int PITCH_MAX    = (MAX_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = PITCH_MAX * MAX_HEIGHT;

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int XB_W    = $clog2(PITCH_MAX);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int PITCH_W = $clog2(PITCH_MAX + 1);
    localparam int PAL_W   = $clog2(PALETTE_SIZE);

    // Field widths
    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 16;
    localparam int COORD_W  = 16;
    localparam int RADDR_W  = 14;
    localparam int BYTE_W   = 8;
    localparam int WCFG_W   = 10;
    localparam int HCFG_W   = 9;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Opcodes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Result kinds
    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_WIDTH      = 3'd0;
    localparam logic [2:0] REG_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_INVERT     = 3'd2;
    localparam logic [2:0] REG_TRANS_EN   = 3'd3;
    localparam logic [2:0] REG_TRANS_IDX  = 3'd4;
    localparam logic [2:0] REG_BG_IDX     = 3'd5;
    localparam logic [2:0] REG_RESTORE    = 3'd6;

    // Register reset values
    localparam logic [WCFG_W-1:0] RST_WIDTH  = 10'd296;
    localparam logic [HCFG_W-1:0] RST_HEIGHT = 9'd128;
    localparam logic              RST_INVERT = 1'b1;

    typedef struct packed {
        logic [WCFG_W-1:0] width;
        logic [HCFG_W-1:0] height;
        logic              invert;
        logic              trans_en;
        logic [IDX_W-1:0]  trans_idx;
        logic [IDX_W-1:0]  bg_idx;
        logic              restore;
    } t_ipw_cfg;

    typedef struct packed {
        logic clear;    // write zero at the clear counter
        logic capture;  // latch the accepted item
        logic calc;     // address calc, palette write, memory reads
        logic commit;   // frame write back and output load
    } t_ipw_cmd;

    typedef struct packed {
        logic clear_last;   // clear counter at the last byte
        logic need_result;  // captured item produces a result
        logic out_free;     // output register can take a result
    } t_ipw_sts;

    // Threshold an RGB565 color: gray = 8*(r+g+b), bit = gray >= 512
    function automatic logic gray_bit(input logic [COLOR_W-1:0] color);
        logic [9:0] r8;
        logic [9:0] g8;
        logic [9:0] b8;
        logic [9:0] gray;
        r8   = {2'b00, color[15:11], 3'b000};
        g8   = {1'b0, color[10:5], 3'b000};
        b8   = {2'b00, color[4:0], 3'b000};
        gray = r8 + g8 + b8;
        return gray[9];
    endfunction

endpackage

// File: rtl/ipw_if.sv
// ============================================================================
// ipw_if: item and result channel interfaces
// Valid/ready channels carrying the pixel command and the byte result.
// ============================================================================
interface ipw_item_if;
    import ipw_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [IDX_W-1:0]   pixel_index;
    logic [RADDR_W-1:0] read_address;

    modport source (
        output valid, opcode, entry_index, entry_color, pixel_x, pixel_y,
               pixel_index, read_address,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_color, pixel_x, pixel_y,
               pixel_index, read_address,
        output ready
    );
endinterface

interface ipw_result_if;
    import ipw_pkg::*;

    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [ADDR_W-1:0]  result_address;
    logic [BYTE_W-1:0]  result_byte;

    modport source (
        output valid, result_kind, result_address, result_byte,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_address, result_byte,
        output ready
    );
endinterface

// File: rtl/ipw_cfg_regs.sv
// ============================================================================
// ipw_cfg_regs: APB configuration registers
// Seven control registers at 4-byte spacing; zero-wait writes and reads.
// ============================================================================
module ipw_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ipw_pkg::CFG_AW-1:0] paddr,
    input  logic [ipw_pkg::CFG_DW-1:0] pwdata,
    output logic [ipw_pkg::CFG_DW-1:0] prdata,
    output logic                      pready,
    output ipw_pkg::t_ipw_cfg         o_cfg
);
    import ipw_pkg::*;

    t_ipw_cfg   r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width     <= RST_WIDTH;
            r_cfg.height    <= RST_HEIGHT;
            r_cfg.invert    <= RST_INVERT;
            r_cfg.trans_en  <= 1'b0;
            r_cfg.trans_idx <= '0;
            r_cfg.bg_idx    <= '0;
            r_cfg.restore   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:     r_cfg.width     <= pwdata[WCFG_W-1:0];
                REG_HEIGHT:    r_cfg.height    <= pwdata[HCFG_W-1:0];
                REG_INVERT:    r_cfg.invert    <= pwdata[0];
                REG_TRANS_EN:  r_cfg.trans_en  <= pwdata[0];
                REG_TRANS_IDX: r_cfg.trans_idx <= pwdata[IDX_W-1:0];
                REG_BG_IDX:    r_cfg.bg_idx    <= pwdata[IDX_W-1:0];
                REG_RESTORE:   r_cfg.restore   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_WIDTH:     prdata = CFG_DW'(r_cfg.width);
            REG_HEIGHT:    prdata = CFG_DW'(r_cfg.height);
            REG_INVERT:    prdata = CFG_DW'(r_cfg.invert);
            REG_TRANS_EN:  prdata = CFG_DW'(r_cfg.trans_en);
            REG_TRANS_IDX: prdata = CFG_DW'(r_cfg.trans_idx);
            REG_BG_IDX:    prdata = CFG_DW'(r_cfg.bg_idx);
            REG_RESTORE:   prdata = CFG_DW'(r_cfg.restore);
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/ipw_ctrl.sv
// ============================================================================
// ipw_ctrl: sequencing state machine
// Runs the post-reset clearing pass, then steps each item through
// capture and calculate, plus commit for an item with a result.
// ============================================================================
module ipw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ipw_pkg::t_ipw_sts i_sts,
    output ipw_pkg::t_ipw_cmd o_cmd
);
    import ipw_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;
    localparam logic [1:0] S_MOD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_sts.need_result ? S_MOD : S_IDLE;
            end
            S_MOD: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/ipw_dp.sv
// ============================================================================
// ipw_dp: palette, framebuffer and result datapath
// Holds the item registers, palette bit memory, framebuffer memory with
// clear counter, address arithmetic, read-modify-write and output register.
// ============================================================================
module ipw_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipw_pkg::t_ipw_cmd           i_cmd,
    output ipw_pkg::t_ipw_sts           o_sts,
    input  ipw_pkg::t_ipw_cfg           i_cfg,
    input  logic [ipw_pkg::OP_W-1:0]    i_opcode,
    input  logic [ipw_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [ipw_pkg::COLOR_W-1:0] i_entry_color,
    input  logic [ipw_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [ipw_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [ipw_pkg::IDX_W-1:0]   i_pixel_index,
    input  logic [ipw_pkg::RADDR_W-1:0] i_read_address,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_result_kind,
    output logic [ipw_pkg::ADDR_W-1:0]  o_result_address,
    output logic [ipw_pkg::BYTE_W-1:0]  o_result_byte
);
    import ipw_pkg::*;

    // Captured item
    logic [OP_W-1:0]    r_op;
    logic [IDX_W-1:0]   r_eidx;
    logic [COLOR_W-1:0] r_ecolor;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [IDX_W-1:0]   r_pidx;
    logic [RADDR_W-1:0] r_raddr;

    // Calc stage results
    logic [ADDR_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_mask;
    logic               r_pal_bit;
    logic [BYTE_W-1:0]  r_fb_q;

    // Memories
    logic               r_pal [PALETTE_SIZE];
    logic [BYTE_W-1:0]  r_fb  [STORE_BYTES];

    logic [ADDR_W-1:0]  r_clr_cnt;

    // Output register
    logic               r_out_valid;
    logic               r_kind;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [BYTE_W-1:0]  r_res_byte;

    // Combinational
    logic [WCFG_W-1:0]          w_sat;
    logic [HCFG_W-1:0]          h_sat;
    logic [WCFG_W:0]            w_round;
    logic [PITCH_W-1:0]         pitch;
    logic [Y_W+PITCH_W-1:0]     row_base;
    logic [ADDR_W-1:0]          draw_addr;
    logic [ADDR_W-1:0]          fb_raddr;
    logic [IDX_W-1:0]           eff_idx;
    logic                       is_trans;
    logic                       skip;
    logic                       drop;
    logic                       bit_clears;
    logic [BYTE_W-1:0]          new_byte;
    logic                       fb_we;
    logic [ADDR_W-1:0]          fb_waddr;
    logic [BYTE_W-1:0]          fb_wdata;

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_eidx   <= i_entry_index;
            r_ecolor <= i_entry_color;
            r_x      <= i_pixel_x;
            r_y      <= i_pixel_y;
            r_pidx   <= i_pixel_index;
            r_raddr  <= i_read_address;
        end
    end

    // Saturate the display size and derive the row pitch in bytes
    always_comb begin
        w_sat   = (i_cfg.width > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : i_cfg.width;
        h_sat   = (i_cfg.height > HCFG_W'(MAX_HEIGHT)) ? HCFG_W'(MAX_HEIGHT) : i_cfg.height;
        w_round = {1'b0, w_sat} + (WCFG_W+1)'(7);
        pitch   = PITCH_W'(w_round >> 3);
    end

    // Index substitution, transparency skip and clipping
    always_comb begin
        is_trans = (r_pidx == i_cfg.trans_idx);
        eff_idx  = (i_cfg.restore && is_trans) ? i_cfg.bg_idx : r_pidx;
        skip     = !i_cfg.restore && i_cfg.trans_en && is_trans;
        drop     = skip || (r_x >= COORD_W'(w_sat)) || (r_y >= COORD_W'(h_sat));
    end

    // Byte address: x/8 + y*pitch
    always_comb begin
        row_base  = r_y[Y_W-1:0] * pitch;
        draw_addr = ADDR_W'(r_x[XB_W+2:3]) + ADDR_W'(row_base);
        fb_raddr  = (r_op == OP_READ) ? r_raddr : draw_addr;
    end

    // Status toward the controller
    always_comb begin
        o_sts.clear_last  = (r_clr_cnt == ADDR_W'(STORE_BYTES - 1));
        o_sts.need_result = ((r_op == OP_DRAW) && !drop) || (r_op == OP_READ);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // Calc stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr <= draw_addr;
            r_mask <= BYTE_W'(8'h80 >> r_x[2:0]);
        end
    end

    // Palette bit memory: load write and draw lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc && (r_op == OP_LOAD)) begin
            r_pal[r_eidx[PAL_W-1:0]] <= gray_bit(r_ecolor);
        end
        if (i_cmd.calc) begin
            r_pal_bit <= r_pal[eff_idx[PAL_W-1:0]];
        end
    end

    // Modify the fetched byte
    always_comb begin
        bit_clears = (r_pal_bit == i_cfg.invert);
        new_byte   = bit_clears ? (r_fb_q & ~r_mask) : (r_fb_q | r_mask);
    end

    // Framebuffer write port: clearing pass or draw write back
    always_comb begin
        fb_we    = i_cmd.clear || (i_cmd.commit && (r_op == OP_DRAW));
        fb_waddr = i_cmd.clear ? r_clr_cnt : r_addr;
        fb_wdata = i_cmd.clear ? '0 : new_byte;
    end

    // Framebuffer memory
    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[fb_waddr] <= fb_wdata;
        end
        if (i_cmd.calc) begin
            r_fb_q <= r_fb[fb_raddr];
        end
    end

    // Advance the clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_op == OP_READ) begin
                r_kind     <= KIND_READ;
                r_res_addr <= r_raddr;
                r_res_byte <= r_fb_q;
            end else begin
                r_kind     <= KIND_DRAW;
                r_res_addr <= r_addr;
                r_res_byte <= new_byte;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_result_address = r_res_addr;
    assign o_result_byte    = r_res_byte;

endmodule

// File: rtl/indexed_pixel_to_1bpp_writer_top.sv
// ============================================================================
// indexed_pixel_to_1bpp_writer_top: palette threshold 1bpp framebuffer writer
// Loads palette bits from RGB565 colors, draws indexed pixels into a
// byte-wide 1bpp framebuffer by read-modify-write, and reads bytes back.
// ============================================================================
//
//  Channel   Dir   Handshake           Carries
//  --------  ----  ------------------  ------------------------------------
//  i_item    in    valid / ready       opcode, palette entry, pixel, address
//  o_result  out   valid / ready       kind, byte address, byte value
//  APB       in    psel/penable/pready 7 control registers at 4*index
//
//  A load, a skipped or dropped draw and an unused opcode take accept and
//  address calc only; a drawn pixel or a read takes accept, address calc
//  with palette and framebuffer reads, then modify and write back, on the
//  single framebuffer read port. After reset a clearing pass writes all
//  16384 framebuffer bytes, one per cycle, with i_item.ready low. A stalled
//  result holds the output register; the next item is accepted meanwhile and,
//  if it has a result, waits in its modify step until that register frees.
//
module indexed_pixel_to_1bpp_writer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ipw_item_if.sink                   i_item,
    ipw_result_if.source               o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipw_pkg::CFG_AW-1:0] paddr,
    input  logic [ipw_pkg::CFG_DW-1:0] pwdata,
    output logic [ipw_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import ipw_pkg::*;

    t_ipw_cfg cfg;
    t_ipw_cmd cmd;
    t_ipw_sts sts;

    // Control registers
    ipw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    ipw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    ipw_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (cfg),
        .i_opcode         (i_item.opcode),
        .i_entry_index    (i_item.entry_index),
        .i_entry_color    (i_item.entry_color),
        .i_pixel_x        (i_item.pixel_x),
        .i_pixel_y        (i_item.pixel_y),
        .i_pixel_index    (i_item.pixel_index),
        .i_read_address   (i_item.read_address),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_result_kind    (o_result.result_kind),
        .o_result_address (o_result.result_address),
        .o_result_byte    (o_result.result_byte)
    );

endmodule

// File: rtl/ipw_checker.sv
// ============================================================================
// ipw_checker: port-level assertions for the 1bpp writer
// Checks reset clearing, per-item sequencing and result handshake timing.
// ============================================================================
module ipw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // Clearing pass holds off items right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("item ready during framebuffer clear");

    // One item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("ready high right after an accept");

    // A fresh result follows its accept through the calc and modify states
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 3))
        else $error("result without a matching item");

    // Hold a pending result until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind indexed_pixel_to_1bpp_writer_top ipw_checker u_ipw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
